@@ hw/rtl/ufcr_pkg.sv @@
// ============================================================================
// ufcr_pkg: shared definitions for the frame chunk reassembler
// Codes, header constants, reset values and the inter-module structs.
// ============================================================================
package ufcr_pkg;

    // Default sizes handed to the top level parameters.
    localparam int MAX_CHUNKS_DEF   = 128;
    localparam int BUFFER_BYTES_DEF = 32768;

    // Fixed field widths.
    localparam int STRIDE_W = 12;
    localparam int WOFF_W   = 15;
    localparam int LEN_W    = 11;

    // Header constants.
    localparam logic [15:0]      MAGIC           = 16'h5354;
    localparam logic [LEN_W-1:0] HDR_BYTES       = 11'd15;
    localparam logic [LEN_W-1:0] CFG_MIN_PAYLOAD = 11'd10;
    localparam logic [7:0]       KIND_CFG        = 8'd1;
    localparam logic [7:0]       KIND_DATA       = 8'd2;
    localparam logic [15:0]      NO_FRAME        = 16'hFFFF;
    localparam logic [15:0]      IDLE_MAX        = 16'hFFFF;

    // Configuration reset values.
    localparam logic [15:0]         IDLE_TIMEOUT_RST = 16'd2000;
    localparam logic [STRIDE_W-1:0] CHUNK_STRIDE_RST = 12'd1000;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_TICK    = 3'd0,
        ST_BAD     = 3'd1,
        ST_CFG     = 3'd2,
        ST_STORED  = 3'd3,
        ST_DISCARD = 3'd4,
        ST_OTHER   = 3'd5
    } t_status;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_STREAM_EN    = 2'd0,
        CFG_IDLE_TIMEOUT = 2'd1,
        CFG_CHUNK_STRIDE = 2'd2
    } t_cfg_idx;

    // Configuration register set.
    typedef struct packed {
        logic                stream_enabled;
        logic [15:0]         idle_timeout_ms;
        logic [STRIDE_W-1:0] chunk_stride;
    } t_cfg;

    // Decoded item passed from the decode stage to the tracker.
    typedef struct packed {
        logic              is_tick;
        logic              pkt_ok;
        logic              kind_cfg;
        logic              kind_data;
        logic              cfg_long;
        logic              chunk_ok;
        logic [15:0]       frame_number;
        logic [15:0]       chunk_total;
        logic [31:0]       frame_bytes;
        logic [WOFF_W-1:0] write_offset;
        logic [LEN_W-1:0]  write_length;
    } t_dec;

endpackage

@@ hw/rtl/ufcr_in_if.sv @@
// ============================================================================
// ufcr_in_if: input item channel
// Valid/ready channel carrying one parsed packet header or one tick.
// ============================================================================
interface ufcr_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [10:0] packet_length;
    logic [15:0] magic_word;
    logic [7:0]  packet_kind;
    logic [15:0] frame_number;
    logic [15:0] chunk_index;
    logic [15:0] chunk_total;
    logic [31:0] frame_bytes;

    modport source (
        output valid, mode, packet_length, magic_word, packet_kind,
               frame_number, chunk_index, chunk_total, frame_bytes,
        input  ready
    );
    modport sink (
        input  valid, mode, packet_length, magic_word, packet_kind,
               frame_number, chunk_index, chunk_total, frame_bytes,
        output ready
    );
endinterface

@@ hw/rtl/ufcr_out_if.sv @@
// ============================================================================
// ufcr_out_if: result item channel
// Valid/ready channel carrying one result per input item.
// ============================================================================
interface ufcr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [14:0] write_offset;
    logic [10:0] write_length;
    logic        frame_done;
    logic [31:0] done_size;
    logic        stream_active;

    modport source (
        output valid, status, write_offset, write_length, frame_done,
               done_size, stream_active,
        input  ready
    );
    modport sink (
        input  valid, status, write_offset, write_length, frame_done,
               done_size, stream_active,
        output ready
    );
endinterface

@@ hw/rtl/ufcr_decode.sv @@
// ============================================================================
// ufcr_decode: header check and chunk placement stage
// Checks length and magic, computes the buffer offset and the fit test,
// and registers the decoded item for the tracker.
// ============================================================================
module ufcr_decode #(
    parameter int MAX_CHUNKS   = ufcr_pkg::MAX_CHUNKS_DEF,
    parameter int BUFFER_BYTES = ufcr_pkg::BUFFER_BYTES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    ufcr_in_if.sink            i_in,
    input  ufcr_pkg::t_cfg     i_cfg,
    output ufcr_pkg::t_dec     o_dec,
    output logic [((MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1)-1:0] o_dec_idx,
    output logic               o_dec_valid,
    input  logic               i_dec_ready
);
    localparam int IDX_W  = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int OFF_W  = IDX_W + ufcr_pkg::STRIDE_W;
    localparam int OFFX_W = (OFF_W > ufcr_pkg::WOFF_W) ? OFF_W : ufcr_pkg::WOFF_W;
    localparam int SUM_W  = OFF_W + 1;
    localparam int BUF_W  = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W  = (SUM_W > BUF_W) ? SUM_W : BUF_W;

    logic                       r_valid;
    ufcr_pkg::t_dec             r_dec;
    logic [IDX_W-1:0]           r_idx;
    ufcr_pkg::t_dec             n_dec;
    logic [IDX_W-1:0]           w_idx;
    logic [ufcr_pkg::LEN_W-1:0] w_pay;
    logic [OFF_W-1:0]           w_off;
    logic [OFFX_W-1:0]          w_off_x;
    logic                       w_in_range;
    logic                       w_fits;
    logic                       w_accept;

    // The stage takes an item when it is empty or its item moves on.
    assign i_in.ready = !r_valid || i_dec_ready;
    assign w_accept   = i_in.valid && i_in.ready;

    // Chunk placement: offset is index times stride, then the buffer fit test.
    assign w_idx      = i_in.chunk_index[IDX_W-1:0];
    assign w_pay      = i_in.packet_length - ufcr_pkg::HDR_BYTES;
    assign w_off      = OFF_W'(w_idx) * OFF_W'(i_cfg.chunk_stride);
    assign w_off_x    = OFFX_W'(w_off);
    assign w_in_range = ({1'b0, i_in.chunk_index} < 17'(MAX_CHUNKS)) &&
                        (i_in.chunk_index < i_in.chunk_total);
    assign w_fits     = (CMP_W'(w_off) + CMP_W'(w_pay)) <= CMP_W'(BUFFER_BYTES);

    // Header decode.
    always_comb begin
        n_dec              = '0;
        n_dec.is_tick      = i_in.mode;
        n_dec.pkt_ok       = (i_in.packet_length >= ufcr_pkg::HDR_BYTES) &&
                             (i_in.magic_word == ufcr_pkg::MAGIC);
        n_dec.kind_cfg     = (i_in.packet_kind == ufcr_pkg::KIND_CFG);
        n_dec.kind_data    = (i_in.packet_kind == ufcr_pkg::KIND_DATA);
        n_dec.cfg_long     = (w_pay >= ufcr_pkg::CFG_MIN_PAYLOAD);
        n_dec.chunk_ok     = w_in_range && w_fits;
        n_dec.frame_number = i_in.frame_number;
        n_dec.chunk_total  = i_in.chunk_total;
        n_dec.frame_bytes  = i_in.frame_bytes;
        n_dec.write_offset = w_off_x[ufcr_pkg::WOFF_W-1:0];
        n_dec.write_length = w_pay;
    end

    // Stage valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    // Decoded payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dec <= n_dec;
            r_idx <= w_idx;
        end
    end

    assign o_dec       = r_dec;
    assign o_dec_idx   = r_idx;
    assign o_dec_valid = r_valid;

endmodule

@@ hw/rtl/ufcr_track.sv @@
// ============================================================================
// ufcr_track: frame state tracker and result register
// Keeps the frame in progress, the seen chunks, the idle timer and the
// active flag, and registers one result per item.
// ============================================================================
module ufcr_track #(
    parameter int MAX_CHUNKS = ufcr_pkg::MAX_CHUNKS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ufcr_pkg::t_cfg i_cfg,
    input  ufcr_pkg::t_dec i_dec,
    input  logic [((MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1)-1:0] i_dec_idx,
    input  logic           i_dec_valid,
    output logic           o_dec_ready,
    ufcr_out_if.source     o_out
);
    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
    localparam int CNT_W = $clog2(MAX_CHUNKS + 1);

    // Frame and timer state.
    logic                  r_frame_valid, n_frame_valid;
    logic [15:0]           r_frame, n_frame;
    logic [MAX_CHUNKS-1:0] r_seen, n_seen;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_active, n_active;
    logic [15:0]           r_idle, n_idle;

    // Result register.
    logic                       r_out_valid;
    ufcr_pkg::t_status          r_status, n_status;
    logic [ufcr_pkg::WOFF_W-1:0] r_woff, n_woff;
    logic [ufcr_pkg::LEN_W-1:0] r_wlen, n_wlen;
    logic                       r_done, n_done;
    logic [31:0]                r_dsize, n_dsize;

    logic              w_take;
    logic [15:0]       w_diff;
    logic              w_older;
    logic              w_open;
    logic              w_seen;
    logic [CNT_W-1:0]  w_count_base;
    logic [CNT_W-1:0]  w_count_inc;
    logic              w_store;
    logic [15:0]       w_idle_inc;

    assign o_dec_ready = !r_out_valid || o_out.ready;
    assign w_take      = i_dec_valid && o_dec_ready;

    // Frame age under 16-bit wrap; half the range apart counts as older.
    assign w_diff       = i_dec.frame_number - r_frame;
    assign w_older      = r_frame_valid && w_diff[15];
    assign w_open       = !r_frame_valid || (!w_diff[15] && (w_diff != 16'd0));
    assign w_seen       = w_open ? 1'b0 : r_seen[i_dec_idx];
    assign w_count_base = w_open ? '0 : r_count;
    assign w_count_inc  = w_count_base + CNT_W'(1);
    assign w_store      = i_dec.kind_data && i_cfg.stream_enabled && !w_older &&
                          i_dec.chunk_ok && !w_seen;
    assign w_idle_inc   = (r_idle == ufcr_pkg::IDLE_MAX) ? r_idle : r_idle + 16'd1;

    // Per-item state update and result.
    always_comb begin
        n_frame_valid = r_frame_valid;
        n_frame       = r_frame;
        n_seen        = r_seen;
        n_count       = r_count;
        n_active      = r_active;
        n_idle        = r_idle;
        n_status      = ufcr_pkg::ST_TICK;
        n_woff        = '0;
        n_wlen        = '0;
        n_done        = 1'b0;
        n_dsize       = '0;
        if (i_dec.is_tick) begin
            n_idle = w_idle_inc;
            if (r_active && (w_idle_inc > i_cfg.idle_timeout_ms)) begin
                n_active = 1'b0;
            end
        end else if (!i_dec.pkt_ok) begin
            n_status = ufcr_pkg::ST_BAD;
        end else begin
            n_idle = '0;
            if (i_dec.kind_cfg) begin
                if (!i_dec.cfg_long) begin
                    n_status = ufcr_pkg::ST_BAD;
                end else begin
                    n_active      = 1'b1;
                    n_frame_valid = 1'b0;
                    n_frame       = ufcr_pkg::NO_FRAME;
                    n_status      = ufcr_pkg::ST_CFG;
                end
            end else if (i_dec.kind_data) begin
                n_status = ufcr_pkg::ST_DISCARD;
                if (i_cfg.stream_enabled) begin
                    // Open a new frame first, even if the chunk is then dropped.
                    if (w_open) begin
                        n_frame_valid = 1'b1;
                        n_frame       = i_dec.frame_number;
                        n_count       = '0;
                    end
                    for (int k = 0; k < MAX_CHUNKS; k++) begin
                        n_seen[k] = (w_open ? 1'b0 : r_seen[k]) |
                                    (w_store && (i_dec_idx == IDX_W'(k)));
                    end
                    if (w_store) begin
                        n_count  = w_count_inc;
                        n_status = ufcr_pkg::ST_STORED;
                        n_woff   = i_dec.write_offset;
                        n_wlen   = i_dec.write_length;
                        if (16'(w_count_inc) == i_dec.chunk_total) begin
                            n_done  = 1'b1;
                            n_dsize = i_dec.frame_bytes;
                        end
                    end
                end
            end else begin
                n_status = ufcr_pkg::ST_OTHER;
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= 1'b0;
            r_frame       <= ufcr_pkg::NO_FRAME;
            r_seen        <= '0;
            r_count       <= '0;
            r_active      <= 1'b0;
            r_idle        <= '0;
        end else if (w_take) begin
            r_frame_valid <= n_frame_valid;
            r_frame       <= n_frame;
            r_seen        <= n_seen;
            r_count       <= n_count;
            r_active      <= n_active;
            r_idle        <= n_idle;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_dec_ready) begin
            r_out_valid <= i_dec_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status <= n_status;
            r_woff   <= n_woff;
            r_wlen   <= n_wlen;
            r_done   <= n_done;
            r_dsize  <= n_dsize;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.write_offset  = r_woff;
    assign o_out.write_length  = r_wlen;
    assign o_out.frame_done    = r_done;
    assign o_out.done_size     = r_dsize;
    assign o_out.stream_active = r_active;

    // The count of stored chunks matches the seen bits of the open frame.
    a_count_matches_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_valid |-> ($countones(r_seen) == 32'(r_count)))
        else $error("chunk count disagrees with seen bits");

    // A completed frame is only ever reported on a stored chunk.
    a_done_on_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_done) |-> (r_status == ufcr_pkg::ST_STORED))
        else $error("frame done without a stored chunk");

    // Offset, length and size stay zero unless the chunk was stored.
    a_zero_unless_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status != ufcr_pkg::ST_STORED)) |->
        ((r_woff == '0) && (r_wlen == '0) && (r_dsize == '0)))
        else $error("write fields set on a result that stored nothing");

    // A tick never raises the active flag.
    a_tick_no_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_dec.is_tick && !r_active) |=> !r_active)
        else $error("active flag raised by a tick");

endmodule

@@ hw/rtl/udp_frame_chunk_reassembler_top.sv @@
// ============================================================================
// udp_frame_chunk_reassembler_top: datagram frame chunk reassembler
// Header-level decisions for chunked frame reassembly: packet checks,
// frame tracking, chunk placement, completion and idle timeout.
// ============================================================================
//
//  Channel   Direction  Handshake        Content
//  i_in      in         valid/ready      packet header or 1 ms tick
//  o_out     out        valid/ready      status and chunk placement
//  i_cfg_*   in         write enable     stream enable, timeout, stride
//
//  One item is accepted per cycle while the result channel is not stalled;
//  its result passes the decode register, then the result register.
//  The frame state is updated in a single stage, so items follow each
//  other back to back with no hazard.
//  A stalled result holds the result register; the decode stage keeps
//  taking items until it is full as well.
//  Synchronous active-low reset clears the frame state, the seen bits,
//  the timer, the active flag and the configuration to defaults.
//
module udp_frame_chunk_reassembler_top #(
    parameter int MAX_CHUNKS   = ufcr_pkg::MAX_CHUNKS_DEF,
    parameter int BUFFER_BYTES = ufcr_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ufcr_in_if.sink     i_in,
    ufcr_out_if.source  o_out,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int IDX_W = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;

    ufcr_pkg::t_cfg   r_cfg;
    ufcr_pkg::t_dec   w_dec;
    logic [IDX_W-1:0] w_dec_idx;
    logic             w_dec_valid;
    logic             w_dec_ready;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stream_enabled  <= 1'b0;
            r_cfg.idle_timeout_ms <= ufcr_pkg::IDLE_TIMEOUT_RST;
            r_cfg.chunk_stride    <= ufcr_pkg::CHUNK_STRIDE_RST;
        end else if (i_cfg_we) begin
            unique case (ufcr_pkg::t_cfg_idx'(i_cfg_idx))
                ufcr_pkg::CFG_STREAM_EN: begin
                    r_cfg.stream_enabled <= i_cfg_data[0];
                end
                ufcr_pkg::CFG_IDLE_TIMEOUT: begin
                    r_cfg.idle_timeout_ms <= i_cfg_data;
                end
                ufcr_pkg::CFG_CHUNK_STRIDE: begin
                    r_cfg.chunk_stride <= i_cfg_data[ufcr_pkg::STRIDE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Header decode and placement stage.
    ufcr_decode #(
        .MAX_CHUNKS   (MAX_CHUNKS),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_dec       (w_dec),
        .o_dec_idx   (w_dec_idx),
        .o_dec_valid (w_dec_valid),
        .i_dec_ready (w_dec_ready)
    );

    // Frame tracking and result stage.
    ufcr_track #(
        .MAX_CHUNKS (MAX_CHUNKS)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_dec       (w_dec),
        .i_dec_idx   (w_dec_idx),
        .i_dec_valid (w_dec_valid),
        .o_dec_ready (w_dec_ready),
        .o_out       (o_out)
    );

endmodule
